// ----- rtl/core/oale_pkg.sv -----
package oale_pkg;

    localparam int CAPACITY = 64;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 7;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int LANES    = 8;
    localparam int GROUPS   = (CAPACITY + LANES - 1) / LANES;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_ERASE  = 3'd4,
        OP_RESIZE = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic               do_get;
        logic               do_set;
        logic               do_append;
        logic               do_insert;
        logic               do_erase;
        logic               do_resize;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   cnt;
        logic [POS_W-1:0]   target;
        logic [WORD_W-1:0]  value;
    } cell_cmd_t;

endpackage

// ----- rtl/core/oale_cell.sv -----
module oale_cell
    import oale_pkg::*;
(
    input  logic              clk,
    input  logic [POS_W-1:0]  index,
    input  cell_cmd_t         cmd,
    input  logic [WORD_W-1:0] left,
    input  logic [WORD_W-1:0] right,
    output logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] read_lane
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (cmd.do_set && index == cmd.pos)
        begin
            word_next = cmd.value;
        end
        if (cmd.do_append && index == cmd.cnt)
        begin
            word_next = cmd.value;
        end
        if (cmd.do_insert)
        begin
            if (index > cmd.pos)
            begin
                word_next = left;
            end
            else if (index == cmd.pos)
            begin
                word_next = cmd.value;
            end
        end
        if (cmd.do_erase && index >= cmd.pos)
        begin
            word_next = right;
        end
        if (cmd.do_resize && index >= cmd.cnt && index < cmd.target)
        begin
            word_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign read_lane = (cmd.do_get && index == cmd.pos) ? word_reg : '0;

endmodule

// ----- rtl/core/oale_read_tree.sv -----
module oale_read_tree
    import oale_pkg::*;
(
    input  logic              clk,
    input  logic              capture,
    input  logic [WORD_W-1:0] lane [CAPACITY],
    output logic [WORD_W-1:0] result
);

    logic [WORD_W-1:0] group_reg  [GROUPS];
    logic [WORD_W-1:0] group_next [GROUPS];

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < LANES; k++)
            begin
                if (g * LANES + k < CAPACITY)
                begin
                    group_next[g] = group_next[g] | lane[g * LANES + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            group_reg <= group_next;
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            result = result | group_reg[g];
        end
    end

endmodule

// ----- rtl/core/ordered_array_list_engine.sv -----
// Ordered list of up to 64 signed 32-bit words held in a row of cells. A request
// is taken when start is high and busy is low; its result (read_value, length,
// status) appears with done high for exactly one cycle on the next clock and
// must be taken then, since the block cannot be held off. Every request has
// an accept cycle and a result cycle, and a new one can be taken right after
// done: all cells shift in parallel in the accept cycle, so insert and erase
// cost the same as get, and the get word passes through a registered OR tree
// read out in the result cycle. Refused requests leave the list unchanged.
module ordered_array_list_engine
    import oale_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output logic                     done,
    input  logic [OP_W-1:0]          op,
    input  logic [POS_W-1:0]         position,
    input  logic signed [WORD_W-1:0] value,
    input  logic [POS_W-1:0]         new_length,
    output logic signed [WORD_W-1:0] read_value,
    output logic [POS_W-1:0]         length,
    output logic [ST_W-1:0]          status
);

    localparam logic [POS_W-1:0] CAP_V = POS_W'(CAPACITY);

    state_t            state_reg;
    state_t            state_next;
    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  count_next;
    status_t           status_reg;
    status_t           status_next;
    logic              accept;
    logic              ok;
    cell_cmd_t         cmd;
    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [WORD_W-1:0] read_lane [CAPACITY];
    logic [WORD_W-1:0] tree_word;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        case (op_t'(op))
            OP_GET, OP_SET:
            begin
                if (position >= count_reg)
                begin
                    status_next = ST_BAD_INDEX;
                end
            end
            OP_APPEND:
            begin
                if (count_reg >= CAP_V)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + POS_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (position > count_reg)
                begin
                    status_next = ST_BAD_INDEX;
                end
                else if (count_reg >= CAP_V)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + POS_W'(1);
                end
            end
            OP_ERASE:
            begin
                if (position >= count_reg)
                begin
                    status_next = ST_BAD_INDEX;
                end
                else
                begin
                    count_next = count_reg - POS_W'(1);
                end
            end
            OP_RESIZE:
            begin
                if (new_length > CAP_V)
                begin
                    status_next = ST_TOO_LARGE;
                end
                else
                begin
                    count_next = new_length;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign ok = accept && (status_next == ST_OK);

    always_comb
    begin
        cmd.do_get    = ok && (op_t'(op) == OP_GET);
        cmd.do_set    = ok && (op_t'(op) == OP_SET);
        cmd.do_append = ok && (op_t'(op) == OP_APPEND);
        cmd.do_insert = ok && (op_t'(op) == OP_INSERT);
        cmd.do_erase  = ok && (op_t'(op) == OP_ERASE);
        cmd.do_resize = ok && (op_t'(op) == OP_RESIZE);
        cmd.pos       = position;
        cmd.cnt       = count_reg;
        cmd.target    = new_length;
        cmd.value     = value;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_mid_l
            assign left_word = cell_word[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_mid_r
            assign right_word = cell_word[i+1];
        end

        oale_cell u_cell (
            .clk       (clk),
            .index     (POS_W'(i)),
            .cmd       (cmd),
            .left      (left_word),
            .right     (right_word),
            .word      (cell_word[i]),
            .read_lane (read_lane[i])
        );
    end

    oale_read_tree u_tree (
        .clk     (clk),
        .capture (accept),
        .lane    (read_lane),
        .result  (tree_word)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        busy = 1'b0;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                done = 1'b0;
            end
            S_RESP:
            begin
                busy = 1'b1;
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                done = 1'b0;
            end
        endcase
    end

    assign read_value = tree_word;
    assign length     = count_reg;
    assign status     = status_reg;

endmodule

// ----- rtl/core/oale_checker.sv -----
module oale_checker
    import oale_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     done,
    input  logic signed [WORD_W-1:0] read_value,
    input  logic [POS_W-1:0]         length,
    input  logic [ST_W-1:0]          status
);

    // every accepted request gets its result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("request without result");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> length <= POS_W'(CAPACITY))
        else $error("length beyond capacity");

    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> read_value == '0)
        else $error("data on refused request");

    // a refused request taken right after the previous result leaves the length alone
    a_refused_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK && $past(done, 2) |-> $stable(length))
        else $error("refused request changed length");

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (.*);
